@@ rtl/core/dpsc_pkg.sv @@
package dpsc_pkg;

  localparam int unsigned STORE_WIDTH  = 1024;
  localparam int unsigned STORE_HEIGHT = 1024;
  localparam int unsigned COL_W  = $clog2(STORE_WIDTH);
  localparam int unsigned ROW_W  = $clog2(STORE_HEIGHT);
  localparam int unsigned ADDR_W = $clog2(STORE_WIDTH * STORE_HEIGHT);
  localparam int unsigned DEPTH  = STORE_WIDTH * STORE_HEIGHT;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_WR   = 4'd2;
  localparam logic [3:0] ST_IDLE = 4'd4;
  localparam logic [3:0] ST_BAD  = 4'd8;

  localparam logic [2:0] CMD_NOP   = 3'd0;
  localparam logic [2:0] CMD_CAP   = 3'd1;
  localparam logic [2:0] CMD_RECT  = 3'd2;
  localparam logic [2:0] CMD_CHECK = 3'd3;
  localparam logic [2:0] CMD_EXIT  = 3'd4;

  localparam logic [4:0] CAP_RES_LEN   = 5'd12;
  localparam logic [4:0] CHECK_RES_LEN = 5'd4;
  localparam logic [3:0] CAP_ARG_LEN   = 4'd1;
  localparam logic [3:0] RECT_ARG_LEN  = 4'd8;

  localparam logic [7:0] MAGIC_0 = 8'h38;
  localparam logic [7:0] MAGIC_1 = 8'h36;
  localparam logic [7:0] MAGIC_2 = 8'h42;
  localparam logic [7:0] MAGIC_3 = 8'h6F;
  localparam logic [7:0] MAGIC_4 = 8'h78;

  localparam logic [2:0] CFG_EXIT_ALLOWED = 3'd0;
  localparam logic [2:0] CFG_TRIGGER      = 3'd1;
  localparam logic [2:0] CFG_PRESENT      = 3'd2;
  localparam logic [2:0] CFG_DISP_W       = 3'd3;
  localparam logic [2:0] CFG_DISP_H       = 3'd4;
  localparam logic [2:0] CFG_BORDER_W     = 3'd5;
  localparam logic [2:0] CFG_BORDER_H     = 3'd6;

  localparam logic [15:0] UNMAPPED     = 16'hFFFF;
  localparam logic [15:0] TRIGGER_RST  = 16'h0080;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [6:0]  EXIT_MAX     = 7'h7F;

  typedef struct packed {
    logic        exit_allowed;
    logic [15:0] trigger_address;
    logic        display_present;
    logic [10:0] display_width;
    logic [10:0] display_height;
    logic [10:0] border_width;
    logic [10:0] border_height;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [23:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/dpsc_store.sv @@
module dpsc_store (
  input  logic                  clk_i,
  input  dpsc_pkg::store_req_t  req_i,
  output logic [23:0]           rdata_o
);

  logic [23:0] mem [dpsc_pkg::DEPTH];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dpsc_core.sv @@
module dpsc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dpsc_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [15:0]          port_i,
  input  logic [7:0]           write_byte_i,
  input  logic [9:0]           pixel_col_i,
  input  logic [9:0]           pixel_row_i,
  input  logic [23:0]          pixel_rgb_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           read_byte_o,
  output logic                 exit_request_o,
  output logic [6:0]           exit_value_o,
  output logic [15:0]          mapped_base_o,
  output dpsc_pkg::store_req_t store_req_o,
  input  logic [23:0]          store_rdata_i
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EXEC      = 3'd1;
  localparam logic [2:0] S_RDPIX     = 3'd2;
  localparam logic [2:0] S_WALK_RD   = 3'd3;
  localparam logic [2:0] S_WALK_BYTE = 3'd4;
  localparam logic [2:0] S_OUT       = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [1:0]  act_q;
  logic [15:0] port_q;
  logic [7:0]  wb_q;
  logic [9:0]  pcol_q, prow_q;
  logic [23:0] rgb_q;

  logic [2:0]  magic_q, magic_d;
  logic [1:0]  bstage_q, bstage_d;
  logic [7:0]  pend_q, pend_d;
  logic [15:0] io_base_q, io_base_d;
  logic [3:0]  status_q, status_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [3:0]  arg_off_q, arg_off_d, arg_len_q, arg_len_d;
  logic [3:0]  res_cnt_q, res_cnt_d;
  logic [10:0] geo_w_q, geo_w_d, geo_h_q, geo_h_d;
  logic [11:0] geo_tw_q, geo_tw_d, geo_th_q, geo_th_d;
  logic [9:0]  geo_ox_q, geo_ox_d, geo_oy_q, geo_oy_d;
  logic [15:0] size0_q, size0_d, size1_q, size1_d;
  logic [15:0] org0_q, org0_d, org1_q, org1_d;
  logic [31:0] check_q, check_d, crc_q, crc_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [1:0]  bidx_q, bidx_d;
  logic        inside_q, inside_d;

  logic [7:0]  res_rd_q, res_rd_d;
  logic        res_ereq_q, res_ereq_d;
  logic [6:0]  res_eval_q, res_eval_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_rd_q;
  logic        out_ereq_q;
  logic [6:0]  out_eval_q;
  logic [15:0] out_base_q;
  logic        out_load;

  // pixel position of the current rectangle walk point
  logic [17:0] px_x, px_y, lim_x, lim_y;
  logic        px_inside;
  logic [dpsc_pkg::ADDR_W-1:0] px_addr;

  logic        mapped, is_cmd, is_data;
  logic [3:0]  arg_inc;
  logic [4:0]  cnt_inc;
  logic [15:0] geo_word;
  logic [7:0]  pix_byte;
  logic        last_pix;

  always_comb begin
    px_x = $signed({2'b00, col_q}) + $signed({{2{org0_q[15]}}, org0_q});
    px_y = $signed({2'b00, row_q}) + $signed({{2{org1_q[15]}}, org1_q});
    lim_x = (32'(geo_tw_q) < 32'(dpsc_pkg::STORE_WIDTH)) ? 18'(geo_tw_q)
                                                         : 18'(dpsc_pkg::STORE_WIDTH);
    lim_y = (32'(geo_th_q) < 32'(dpsc_pkg::STORE_HEIGHT)) ? 18'(geo_th_q)
                                                          : 18'(dpsc_pkg::STORE_HEIGHT);
    px_inside = !px_x[17] && !px_y[17] && (px_x < lim_x) && (px_y < lim_y);
    px_addr = dpsc_pkg::ADDR_W'(px_y[dpsc_pkg::ROW_W-1:0])
              * dpsc_pkg::ADDR_W'(dpsc_pkg::STORE_WIDTH)
              + dpsc_pkg::ADDR_W'(px_x[dpsc_pkg::COL_W-1:0]);
  end

  always_comb begin
    if (inside_q) begin
      pix_byte = (bidx_q == 2'd3) ? 8'h00 : store_rdata_i[8*bidx_q +: 8];
    end else begin
      pix_byte = (bidx_q == 2'd3) ? 8'hFF : 8'h00;
    end
  end

  assign last_pix = (col_q == size0_q - 16'd1) && (row_q == size1_q - 16'd1);
  assign mapped   = io_base_q != dpsc_pkg::UNMAPPED;
  assign is_cmd   = mapped && (port_q == io_base_q);
  assign is_data  = mapped && (port_q == io_base_q + 16'd1);
  assign arg_inc  = arg_off_q + 4'd1;
  assign cnt_inc  = 5'(res_cnt_q) + 5'd1;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    unique case (res_cnt_q[3:1])
      3'd0:    geo_word = 16'(geo_w_q);
      3'd1:    geo_word = 16'(geo_h_q);
      3'd2:    geo_word = 16'(geo_tw_q);
      3'd3:    geo_word = 16'(geo_th_q);
      3'd4:    geo_word = 16'(geo_ox_q);
      3'd5:    geo_word = 16'(geo_oy_q);
      default: geo_word = 16'h0000;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    magic_d    = magic_q;
    bstage_d   = bstage_q;
    pend_d     = pend_q;
    io_base_d  = io_base_q;
    status_d   = status_q;
    cmd_d      = cmd_q;
    arg_off_d  = arg_off_q;
    arg_len_d  = arg_len_q;
    res_cnt_d  = res_cnt_q;
    geo_w_d    = geo_w_q;
    geo_h_d    = geo_h_q;
    geo_tw_d   = geo_tw_q;
    geo_th_d   = geo_th_q;
    geo_ox_d   = geo_ox_q;
    geo_oy_d   = geo_oy_q;
    size0_d    = size0_q;
    size1_d    = size1_q;
    org0_d     = org0_q;
    org1_d     = org1_q;
    check_d    = check_q;
    crc_d      = crc_q;
    col_d      = col_q;
    row_d      = row_q;
    bidx_d     = bidx_q;
    inside_d   = inside_q;
    res_rd_d   = res_rd_q;
    res_ereq_d = res_ereq_q;
    res_eval_d = res_eval_q;
    store_req_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d    = S_OUT;
        res_rd_d   = 8'hFF;
        res_ereq_d = 1'b0;
        res_eval_d = 7'd0;
        if (act_q == dpsc_pkg::ACT_WRITE) begin
          if (is_cmd) begin
            arg_off_d = 4'd0;
            arg_len_d = 4'd0;
            res_cnt_d = 4'd0;
            col_d     = 16'd0;
            row_d     = 16'd0;
            status_d  = dpsc_pkg::ST_WR;
            if (wb_q == 8'(dpsc_pkg::CMD_NOP)) begin
              cmd_d    = dpsc_pkg::CMD_NOP;
              status_d = dpsc_pkg::ST_IDLE;
            end else if (wb_q == 8'(dpsc_pkg::CMD_CAP)) begin
              cmd_d     = dpsc_pkg::CMD_CAP;
              arg_len_d = dpsc_pkg::CAP_ARG_LEN;
            end else if (wb_q == 8'(dpsc_pkg::CMD_RECT)) begin
              cmd_d     = dpsc_pkg::CMD_RECT;
              arg_len_d = dpsc_pkg::RECT_ARG_LEN;
            end else if (wb_q == 8'(dpsc_pkg::CMD_CHECK)) begin
              cmd_d     = dpsc_pkg::CMD_CHECK;
              arg_len_d = dpsc_pkg::RECT_ARG_LEN;
            end else if (wb_q == 8'(dpsc_pkg::CMD_EXIT)) begin
              cmd_d     = dpsc_pkg::CMD_EXIT;
              arg_len_d = dpsc_pkg::CAP_ARG_LEN;
            end else begin
              cmd_d    = dpsc_pkg::CMD_NOP;
              status_d = dpsc_pkg::ST_IDLE | dpsc_pkg::ST_BAD;
            end
          end else if (is_data && ((status_q & dpsc_pkg::ST_WR) != 4'd0)) begin
            if ((cmd_q == dpsc_pkg::CMD_RECT || cmd_q == dpsc_pkg::CMD_CHECK)
                && !arg_off_q[3]) begin
              // argument bytes: size x, size y, origin x, origin y, low byte first
              unique case ({arg_off_q[2], arg_off_q[1]})
                2'b00: size0_d = arg_off_q[0] ? {wb_q, size0_q[7:0]} : 16'(wb_q);
                2'b01: size1_d = arg_off_q[0] ? {wb_q, size1_q[7:0]} : 16'(wb_q);
                2'b10: org0_d  = arg_off_q[0] ? {wb_q, org0_q[7:0]}  : 16'(wb_q);
                default: org1_d = arg_off_q[0] ? {wb_q, org1_q[7:0]} : 16'(wb_q);
              endcase
            end
            arg_off_d = arg_inc;
            if (arg_inc >= arg_len_q) begin
              status_d = status_q & ~dpsc_pkg::ST_WR;
              if (cmd_q == dpsc_pkg::CMD_EXIT) begin
                if (cfg_i.exit_allowed) begin
                  res_ereq_d = 1'b1;
                  res_eval_d = wb_q[7] ? dpsc_pkg::EXIT_MAX : wb_q[6:0];
                end
                cmd_d    = dpsc_pkg::CMD_NOP;
                status_d = dpsc_pkg::ST_IDLE;
              end else if (cmd_q == dpsc_pkg::CMD_CAP) begin
                if (wb_q == 8'd1 && cfg_i.display_present) begin
                  geo_w_d  = cfg_i.display_width;
                  geo_h_d  = cfg_i.display_height;
                  geo_tw_d = 12'(cfg_i.display_width) + 12'(cfg_i.border_width);
                  geo_th_d = 12'(cfg_i.display_height) + 12'(cfg_i.border_height);
                  geo_ox_d = cfg_i.border_width[10:1];
                  geo_oy_d = cfg_i.border_height[10:1];
                end else begin
                  geo_w_d  = '0;
                  geo_h_d  = '0;
                  geo_tw_d = '0;
                  geo_th_d = '0;
                  geo_ox_d = '0;
                  geo_oy_d = '0;
                end
                status_d = dpsc_pkg::ST_RD;
              end else if (cmd_q == dpsc_pkg::CMD_RECT || cmd_q == dpsc_pkg::CMD_CHECK) begin
                org0_d = org0_d + 16'(geo_ox_q);
                org1_d = org1_d + 16'(geo_oy_q);
                if (cmd_q == dpsc_pkg::CMD_CHECK) begin
                  status_d = dpsc_pkg::ST_RD;
                  if (size0_d == 16'd0 || size1_d == 16'd0) begin
                    check_d = 32'h0;
                  end else begin
                    crc_d   = 32'hFFFFFFFF;
                    col_d   = 16'd0;
                    row_d   = 16'd0;
                    state_d = S_WALK_RD;
                  end
                end else if (size0_d != 16'd0 && size1_d != 16'd0) begin
                  status_d = dpsc_pkg::ST_RD;
                end else begin
                  cmd_d    = dpsc_pkg::CMD_NOP;
                  status_d = dpsc_pkg::ST_IDLE;
                end
              end else begin
                cmd_d    = dpsc_pkg::CMD_NOP;
                status_d = dpsc_pkg::ST_IDLE;
              end
            end
          end
          if (port_q == cfg_i.trigger_address) begin
            if (bstage_q == 2'd1) begin
              pend_d   = wb_q;
              bstage_d = 2'd2;
            end else if (bstage_q == 2'd2) begin
              io_base_d = {wb_q, pend_q};
              bstage_d  = 2'd0;
            end else begin
              bstage_d = 2'd0;
            end
            if (wb_q == dpsc_pkg::MAGIC_0) begin
              magic_d = 3'd1;
            end else if (wb_q == dpsc_pkg::MAGIC_1) begin
              magic_d = (magic_q == 3'd1) ? 3'd2 : 3'd0;
            end else if (wb_q == dpsc_pkg::MAGIC_2) begin
              magic_d = (magic_q == 3'd2) ? 3'd3 : 3'd0;
            end else if (wb_q == dpsc_pkg::MAGIC_3) begin
              magic_d = (magic_q == 3'd3) ? 3'd4 : 3'd0;
            end else if (wb_q == dpsc_pkg::MAGIC_4) begin
              if (magic_q == 3'd4) begin
                bstage_d = 2'd1;
              end
              magic_d = 3'd0;
            end else begin
              magic_d = 3'd0;
            end
          end
        end else if (act_q == dpsc_pkg::ACT_READ) begin
          if (is_cmd) begin
            res_rd_d = {4'h0, status_q};
          end else if (is_data && ((status_q & dpsc_pkg::ST_RD) != 4'd0)) begin
            if (cmd_q == dpsc_pkg::CMD_RECT) begin
              inside_d          = px_inside;
              bidx_d            = res_cnt_q[1:0];
              store_req_o.rd_en = 1'b1;
              store_req_o.rd_addr = px_addr;
              state_d           = S_RDPIX;
            end else begin
              res_cnt_d = cnt_inc[3:0];
              if (cmd_q == dpsc_pkg::CMD_CAP) begin
                res_rd_d = res_cnt_q[0] ? geo_word[15:8] : geo_word[7:0];
                if (cnt_inc >= dpsc_pkg::CAP_RES_LEN) begin
                  cmd_d    = dpsc_pkg::CMD_NOP;
                  status_d = dpsc_pkg::ST_IDLE;
                end
              end else if (cmd_q == dpsc_pkg::CMD_CHECK) begin
                res_rd_d = check_q[8*res_cnt_q[1:0] +: 8];
                if (cnt_inc >= dpsc_pkg::CHECK_RES_LEN) begin
                  cmd_d    = dpsc_pkg::CMD_NOP;
                  status_d = dpsc_pkg::ST_IDLE;
                end
              end else begin
                cmd_d    = dpsc_pkg::CMD_NOP;
                status_d = dpsc_pkg::ST_IDLE;
              end
            end
          end
        end else if (act_q == dpsc_pkg::ACT_LOAD) begin
          if (32'(pcol_q) < 32'(dpsc_pkg::STORE_WIDTH)
              && 32'(prow_q) < 32'(dpsc_pkg::STORE_HEIGHT)) begin
            store_req_o.wr_en   = 1'b1;
            store_req_o.wr_addr = dpsc_pkg::ADDR_W'(prow_q)
                                  * dpsc_pkg::ADDR_W'(dpsc_pkg::STORE_WIDTH)
                                  + dpsc_pkg::ADDR_W'(pcol_q);
            store_req_o.wr_data = rgb_q;
          end
        end
      end
      S_RDPIX: begin
        res_rd_d  = pix_byte;
        res_cnt_d = res_cnt_q + 4'd1;
        state_d   = S_OUT;
        if (bidx_q == 2'd3) begin
          if (last_pix) begin
            cmd_d    = dpsc_pkg::CMD_NOP;
            status_d = dpsc_pkg::ST_IDLE;
          end
          if (col_q == size0_q - 16'd1) begin
            col_d = 16'd0;
            row_d = row_q + 16'd1;
          end else begin
            col_d = col_q + 16'd1;
          end
        end
      end
      S_WALK_RD: begin
        inside_d            = px_inside;
        bidx_d              = 2'd0;
        store_req_o.rd_en   = 1'b1;
        store_req_o.rd_addr = px_addr;
        state_d             = S_WALK_BYTE;
      end
      S_WALK_BYTE: begin
        crc_d  = dpsc_pkg::crc_byte(crc_q, pix_byte);
        bidx_d = bidx_q + 2'd1;
        if (bidx_q == 2'd3) begin
          if (last_pix) begin
            check_d = ~crc_d;
            state_d = S_OUT;
          end else begin
            state_d = S_WALK_RD;
          end
          if (col_q == size0_q - 16'd1) begin
            col_d = 16'd0;
            row_d = row_q + 16'd1;
          end else begin
            col_d = col_q + 16'd1;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      magic_q     <= 3'd0;
      bstage_q    <= 2'd0;
      pend_q      <= 8'd0;
      io_base_q   <= dpsc_pkg::UNMAPPED;
      status_q    <= dpsc_pkg::ST_IDLE;
      cmd_q       <= dpsc_pkg::CMD_NOP;
      arg_off_q   <= 4'd0;
      arg_len_q   <= 4'd0;
      res_cnt_q   <= 4'd0;
      geo_w_q     <= '0;
      geo_h_q     <= '0;
      geo_tw_q    <= '0;
      geo_th_q    <= '0;
      geo_ox_q    <= '0;
      geo_oy_q    <= '0;
      size0_q     <= '0;
      size1_q     <= '0;
      org0_q      <= '0;
      org1_q      <= '0;
      check_q     <= '0;
      crc_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      bidx_q      <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      magic_q     <= magic_d;
      bstage_q    <= bstage_d;
      pend_q      <= pend_d;
      io_base_q   <= io_base_d;
      status_q    <= status_d;
      cmd_q       <= cmd_d;
      arg_off_q   <= arg_off_d;
      arg_len_q   <= arg_len_d;
      res_cnt_q   <= res_cnt_d;
      geo_w_q     <= geo_w_d;
      geo_h_q     <= geo_h_d;
      geo_tw_q    <= geo_tw_d;
      geo_th_q    <= geo_th_d;
      geo_ox_q    <= geo_ox_d;
      geo_oy_q    <= geo_oy_d;
      size0_q     <= size0_d;
      size1_q     <= size1_d;
      org0_q      <= org0_d;
      org1_q      <= org1_d;
      check_q     <= check_d;
      crc_q       <= crc_d;
      col_q       <= col_d;
      row_q       <= row_d;
      bidx_q      <= bidx_d;
      inside_q    <= inside_d;
      out_valid_q <= out_valid_d;
    end
  end

  // transaction payload and staged results
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q  <= action_i;
      port_q <= port_i;
      wb_q   <= write_byte_i;
      pcol_q <= pixel_col_i;
      prow_q <= pixel_row_i;
      rgb_q  <= pixel_rgb_i;
    end
    res_rd_q   <= res_rd_d;
    res_ereq_q <= res_ereq_d;
    res_eval_q <= res_eval_d;
    if (out_load) begin
      out_rd_q   <= res_rd_q;
      out_ereq_q <= res_ereq_q;
      out_eval_q <= res_eval_q;
      out_base_q <= io_base_q;
    end
  end

  assign in_stall_o     = state_q != S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign read_byte_o    = out_rd_q;
  assign exit_request_o = out_ereq_q;
  assign exit_value_o   = out_eval_q;
  assign mapped_base_o  = out_base_q;

endmodule

@@ rtl/core/debug_port_snapshot_checker.sv @@
// Debug I/O port with a screen snapshot checker.
// Input channel (in_valid_i / in_stall_o) carries one bus access or one
// pixel load per transaction; the output channel (out_valid_o / out_stall_i)
// returns exactly one result per input transaction, in order.
// Configuration registers are written over cfg_valid_i / cfg_ready_o with a
// register index and data; ready is always high, write only while idle.
// A plain I/O access or pixel load passes the payload register, the staged
// result and the output register; a rectangle byte read also passes the
// registered read of the snapshot memory. The verify command walks its whole
// rectangle through that memory port and a byte-wide CRC unit, one read and
// then a CRC step for each of the four bytes of a pixel, before it returns
// the result of the argument write that starts it. One transaction is worked
// on at a time. The next is taken once the current result sits in the output
// register, even while it is stalled. A stalled result holds its payload;
// the block then waits with in_stall_o high once a second result is ready.
// Reset returns the port to unmapped (base 0xFFFF), trigger at 0x0080,
// status idle and geometry zero; the snapshot memory is not cleared.
module debug_port_snapshot_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] port_i,
  input  logic [7:0]  write_byte_i,
  input  logic [9:0]  pixel_col_i,
  input  logic [9:0]  pixel_row_i,
  input  logic [23:0] pixel_rgb_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_byte_o,
  output logic        exit_request_o,
  output logic [6:0]  exit_value_o,
  output logic [15:0] mapped_base_o
);

  dpsc_pkg::cfg_t       cfg_q;
  dpsc_pkg::store_req_t store_req;
  logic [23:0]          store_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exit_allowed    <= 1'b1;
      cfg_q.trigger_address <= dpsc_pkg::TRIGGER_RST;
      cfg_q.display_present <= 1'b0;
      cfg_q.display_width   <= '0;
      cfg_q.display_height  <= '0;
      cfg_q.border_width    <= '0;
      cfg_q.border_height   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dpsc_pkg::CFG_EXIT_ALLOWED: cfg_q.exit_allowed    <= cfg_data_i[0];
        dpsc_pkg::CFG_TRIGGER:      cfg_q.trigger_address <= cfg_data_i;
        dpsc_pkg::CFG_PRESENT:      cfg_q.display_present <= cfg_data_i[0];
        dpsc_pkg::CFG_DISP_W:       cfg_q.display_width   <= cfg_data_i[10:0];
        dpsc_pkg::CFG_DISP_H:       cfg_q.display_height  <= cfg_data_i[10:0];
        dpsc_pkg::CFG_BORDER_W:     cfg_q.border_width    <= cfg_data_i[10:0];
        dpsc_pkg::CFG_BORDER_H:     cfg_q.border_height   <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  dpsc_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  dpsc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .port_i         (port_i),
    .write_byte_i   (write_byte_i),
    .pixel_col_i    (pixel_col_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_rgb_i    (pixel_rgb_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_byte_o    (read_byte_o),
    .exit_request_o (exit_request_o),
    .exit_value_o   (exit_value_o),
    .mapped_base_o  (mapped_base_o),
    .store_req_o    (store_req),
    .store_rdata_i  (store_rdata)
  );

endmodule
